// ----- hdl/lzwbd_pkg.sv -----
`timescale 1ns / 1ps

package lzwbd_pkg;

    localparam int CFG_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CNT_W     = 3;
    localparam int RESULT_WORDS = 4;
    // Copy source pointer: covers a 16-bit far position plus a full run, and a
    // near start that falls before position zero.
    localparam int SRC_W     = 18;

    localparam logic [CFG_W-1:0]  CFG_RESET = 13'd4096;
    localparam logic [BYTE_W-1:0] NEAR_TAG  = 8'hA7;
    localparam logic [BYTE_W-1:0] FAR_TAG   = 8'hA8;

    typedef enum logic [2:0] {
        PH_LOW,
        PH_HIGH,
        PH_ESCAPE,
        PH_NEAR_OFS,
        PH_FAR_LOW,
        PH_FAR_HIGH
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NEAR,
        KIND_FAR
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIT,
        S_RD,
        S_WR,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic put_lit;
        logic rd;
        logic put_copy;
        logic flush;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic go_lit;
        logic go_copy;
        logic copy_end;
        logic pend_fill;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/lzwbd_in_if.sv -----
`timescale 1ns / 1ps

interface lzwbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       stream_start;

    modport source (output valid, output stream_byte, output stream_start, input ready);
    modport sink   (input valid, input stream_byte, input stream_start, output ready);
endinterface

// ----- hdl/lzwbd_out_if.sv -----
`timescale 1ns / 1ps

interface lzwbd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [2:0]  word_count;
    logic        run_last;
    logic        output_done;
    logic        reference_error;

    modport source (output valid, output word_a, output word_b, output word_c,
                    output word_d, output word_count, output run_last,
                    output output_done, output reference_error, input ready);
    modport sink   (input valid, input word_a, input word_b, input word_c,
                    input word_d, input word_count, input run_last,
                    input output_done, input reference_error, output ready);
endinterface

// ----- hdl/lzwbd_ctrl.sv -----
`timescale 1ns / 1ps

module lzwbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lzwbd_pkg::t_status i_st,
    output lzwbd_pkg::t_cmd    o_cmd
);

    lzwbd_pkg::t_state r_state, n_state;
    logic              r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwbd_pkg::S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            lzwbd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_st.go_lit) begin
                        n_state = lzwbd_pkg::S_LIT;
                    end else if (i_st.go_copy) begin
                        n_state = lzwbd_pkg::S_RD;
                    end else begin
                        n_state = lzwbd_pkg::S_IDLE;
                    end
                end
            end
            lzwbd_pkg::S_LIT: begin
                n_state = lzwbd_pkg::S_FLUSH;
                n_last  = 1'b1;
            end
            lzwbd_pkg::S_RD: begin
                n_state = lzwbd_pkg::S_WR;
            end
            lzwbd_pkg::S_WR: begin
                priority if (i_st.copy_end) begin
                    n_state = lzwbd_pkg::S_FLUSH;
                    n_last  = 1'b1;
                end else if (i_st.pend_fill) begin
                    n_state = lzwbd_pkg::S_FLUSH;
                    n_last  = 1'b0;
                end else begin
                    n_state = lzwbd_pkg::S_RD;
                end
            end
            lzwbd_pkg::S_FLUSH: begin
                // hold until the output register frees up
                if (i_st.out_free) begin
                    n_state = r_last ? lzwbd_pkg::S_IDLE : lzwbd_pkg::S_RD;
                end
            end
            default: begin
                n_state = lzwbd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == lzwbd_pkg::S_IDLE);
        o_cmd.accept    = (r_state == lzwbd_pkg::S_IDLE) && i_in_valid;
        o_cmd.put_lit   = (r_state == lzwbd_pkg::S_LIT);
        o_cmd.rd        = (r_state == lzwbd_pkg::S_RD);
        o_cmd.put_copy  = (r_state == lzwbd_pkg::S_WR);
        o_cmd.flush     = (r_state == lzwbd_pkg::S_FLUSH) && i_st.out_free;
        o_cmd.last      = r_last;
    end

endmodule

// ----- hdl/lzwbd_dp.sv -----
`timescale 1ns / 1ps

module lzwbd_dp #(
    parameter int HISTORY_WORDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lzwbd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [lzwbd_pkg::BYTE_W-1:0]  i_stream_byte,
    input  logic                          i_stream_start,
    input  lzwbd_pkg::t_cmd               i_cmd,
    output lzwbd_pkg::t_status            o_st,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [lzwbd_pkg::WORD_W-1:0]  o_word_a,
    output logic [lzwbd_pkg::WORD_W-1:0]  o_word_b,
    output logic [lzwbd_pkg::WORD_W-1:0]  o_word_c,
    output logic [lzwbd_pkg::WORD_W-1:0]  o_word_d,
    output logic [lzwbd_pkg::CNT_W-1:0]   o_word_count,
    output logic                          o_run_last,
    output logic                          o_output_done,
    output logic                          o_reference_error
);

    localparam int AW = $clog2(HISTORY_WORDS);
    localparam int PW = $clog2(HISTORY_WORDS + 1);
    localparam int LW = (PW > lzwbd_pkg::CFG_W) ? PW : lzwbd_pkg::CFG_W;
    localparam int SW = lzwbd_pkg::SRC_W;
    localparam int WW = lzwbd_pkg::WORD_W;
    localparam int BW = lzwbd_pkg::BYTE_W;
    localparam int CW = lzwbd_pkg::CNT_W;

    logic [WW-1:0] mem [HISTORY_WORDS];

    // control state
    logic [lzwbd_pkg::CFG_W-1:0] r_cfg;
    lzwbd_pkg::t_phase           r_phase, n_phase;
    lzwbd_pkg::t_kind            r_kind, n_kind;
    logic [BW-1:0]               r_held_low, n_held_low;
    logic [BW-1:0]               r_far_low, n_far_low;
    logic [PW-1:0]               r_wp;
    logic                        r_fin;
    logic [CW-1:0]               r_pend_cnt;
    logic                        r_pend_err;
    logic                        r_out_valid;

    // payload
    logic [WW-1:0] r_pend [lzwbd_pkg::RESULT_WORDS];
    logic [WW-1:0] r_lit;
    logic [SW-1:0] r_src;
    logic [BW-1:0] r_rem;
    logic [WW-1:0] r_rdata;
    logic [WW-1:0] r_word_a, r_word_b, r_word_c, r_word_d;
    logic [CW-1:0] r_word_count;
    logic          r_run_last, r_done, r_err;

    logic [LW-1:0]     lim;
    logic [LW-1:0]     cfg_ext;
    logic [PW-1:0]     wp_eff;
    logic              fin_eff;
    lzwbd_pkg::t_phase phase_eff;
    lzwbd_pkg::t_kind  kind_eff;
    logic [BW-1:0]     held_eff;
    logic [BW-1:0]     far_eff;
    logic              go_lit, go_copy;
    logic [WW-1:0]     lit_val;
    logic [SW-1:0]     copy_src;
    logic              src_ok;
    logic              put;
    logic [WW-1:0]     put_val;
    logic              put_err;
    logic              wp_next_full;

    // clip the register into 1..HISTORY_WORDS
    always_comb begin
        cfg_ext = LW'(r_cfg);
        if (r_cfg == '0) begin
            lim = LW'(1);
        end else if (cfg_ext > LW'(HISTORY_WORDS)) begin
            lim = LW'(HISTORY_WORDS);
        end else begin
            lim = cfg_ext;
        end
    end

    // byte decode, with a stream start clearing the parser first
    always_comb begin
        wp_eff    = i_stream_start ? '0 : r_wp;
        fin_eff   = (i_stream_start ? 1'b0 : r_fin) || (LW'(wp_eff) >= lim);
        phase_eff = i_stream_start ? lzwbd_pkg::PH_LOW : r_phase;
        kind_eff  = i_stream_start ? lzwbd_pkg::KIND_NONE : r_kind;
        held_eff  = i_stream_start ? '0 : r_held_low;
        far_eff   = i_stream_start ? '0 : r_far_low;

        n_phase    = phase_eff;
        n_kind     = kind_eff;
        n_held_low = held_eff;
        n_far_low  = far_eff;
        go_lit     = 1'b0;
        go_copy    = 1'b0;
        lit_val    = '0;
        copy_src   = '0;

        if (!fin_eff) begin
            unique case (phase_eff)
                lzwbd_pkg::PH_LOW: begin
                    n_held_low = i_stream_byte;
                    n_phase    = lzwbd_pkg::PH_HIGH;
                end
                lzwbd_pkg::PH_HIGH: begin
                    if (i_stream_byte == lzwbd_pkg::NEAR_TAG ||
                        i_stream_byte == lzwbd_pkg::FAR_TAG) begin
                        n_kind = (i_stream_byte == lzwbd_pkg::NEAR_TAG) ?
                                 lzwbd_pkg::KIND_NEAR : lzwbd_pkg::KIND_FAR;
                        priority if (held_eff == '0) begin
                            n_phase = lzwbd_pkg::PH_ESCAPE;
                        end else if (i_stream_byte == lzwbd_pkg::NEAR_TAG) begin
                            n_phase = lzwbd_pkg::PH_NEAR_OFS;
                        end else begin
                            n_phase = lzwbd_pkg::PH_FAR_LOW;
                        end
                    end else begin
                        n_phase = lzwbd_pkg::PH_LOW;
                        go_lit  = 1'b1;
                        lit_val = {i_stream_byte, held_eff};
                    end
                end
                lzwbd_pkg::PH_ESCAPE: begin
                    n_phase = lzwbd_pkg::PH_LOW;
                    go_lit  = 1'b1;
                    lit_val = {(kind_eff == lzwbd_pkg::KIND_NEAR) ?
                               lzwbd_pkg::NEAR_TAG : lzwbd_pkg::FAR_TAG, i_stream_byte};
                end
                lzwbd_pkg::PH_NEAR_OFS: begin
                    n_phase  = lzwbd_pkg::PH_LOW;
                    go_copy  = 1'b1;
                    // may go negative: those words come out as bad references
                    copy_src = SW'(wp_eff) - SW'(i_stream_byte);
                end
                lzwbd_pkg::PH_FAR_LOW: begin
                    n_far_low = i_stream_byte;
                    n_phase   = lzwbd_pkg::PH_FAR_HIGH;
                end
                lzwbd_pkg::PH_FAR_HIGH: begin
                    n_phase  = lzwbd_pkg::PH_LOW;
                    go_copy  = 1'b1;
                    copy_src = SW'({i_stream_byte, far_eff});
                end
                default: begin
                    n_phase = lzwbd_pkg::PH_LOW;
                end
            endcase
        end
    end

    always_comb begin
        src_ok       = !r_src[SW-1] && (r_src < SW'(r_wp));
        put          = i_cmd.put_lit || i_cmd.put_copy;
        put_err      = i_cmd.put_copy && !src_ok;
        wp_next_full = (LW'(r_wp) + LW'(1)) >= lim;
        if (i_cmd.put_lit) begin
            put_val = r_lit;
        end else if (src_ok) begin
            put_val = r_rdata;
        end else begin
            put_val = '0;
        end
    end

    always_comb begin
        o_st.go_lit    = go_lit;
        o_st.go_copy   = go_copy;
        o_st.copy_end  = (r_rem == BW'(1)) || wp_next_full;
        o_st.pend_fill = (r_pend_cnt == CW'(lzwbd_pkg::RESULT_WORDS - 1));
        o_st.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= lzwbd_pkg::CFG_RESET;
            r_phase     <= lzwbd_pkg::PH_LOW;
            r_kind      <= lzwbd_pkg::KIND_NONE;
            r_held_low  <= '0;
            r_far_low   <= '0;
            r_wp        <= '0;
            r_fin       <= 1'b0;
            r_pend_cnt  <= '0;
            r_pend_err  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_phase    <= n_phase;
                r_kind     <= n_kind;
                r_held_low <= n_held_low;
                r_far_low  <= n_far_low;
                r_wp       <= wp_eff;
                r_fin      <= fin_eff;
            end
            if (put) begin
                r_wp       <= r_wp + PW'(1);
                r_pend_cnt <= r_pend_cnt + CW'(1);
                if (wp_next_full) begin
                    r_fin <= 1'b1;
                end
                if (put_err) begin
                    r_pend_err <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_out_valid <= 1'b1;
                r_pend_cnt  <= '0;
                r_pend_err  <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lit <= lit_val;
            r_src <= copy_src;
            r_rem <= held_eff;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_src[AW-1:0]];
        end
        if (put) begin
            mem[r_wp[AW-1:0]]      <= put_val;
            r_pend[r_pend_cnt[1:0]] <= put_val;
        end
        if (i_cmd.put_copy) begin
            r_src <= r_src + SW'(1);
            r_rem <= r_rem - BW'(1);
        end
        if (i_cmd.flush) begin
            r_word_a     <= r_pend[0];
            r_word_b     <= (r_pend_cnt >= CW'(2)) ? r_pend[1] : '0;
            r_word_c     <= (r_pend_cnt >= CW'(3)) ? r_pend[2] : '0;
            r_word_d     <= (r_pend_cnt >= CW'(4)) ? r_pend[3] : '0;
            r_word_count <= r_pend_cnt;
            r_run_last   <= i_cmd.last;
            r_done       <= r_fin;
            r_err        <= r_pend_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_word_a          = r_word_a;
    assign o_word_b          = r_word_b;
    assign o_word_c          = r_word_c;
    assign o_word_d          = r_word_d;
    assign o_word_count      = r_word_count;
    assign o_run_last        = r_run_last;
    assign o_output_done     = r_done;
    assign o_reference_error = r_err;

endmodule

// ----- hdl/lz_word_backref_decompressor.sv -----
`timescale 1ns / 1ps

// LZ word back-reference decompressor. Takes one compressed byte per input
// transaction and rebuilds 16-bit little-endian words into a HISTORY_WORDS
// deep history memory, emitting them packed up to four per output
// transaction, with run_last on the final transaction caused by a byte.
// A byte that only advances the parser gives no output. A literal word
// is accepted, stored and then packed on its closing byte. A copy reads
// each word from the single-port history memory and then writes it back,
// and packs its words in groups of up to four per output transaction; a
// full output register that is not drained stalls the block. i_cfg_data
// sets the output size in words (0 acts as 1, values above HISTORY_WORDS are
// clipped); write it only while the block is idle. Output stops when that
// size is reached, until the next byte flagged stream_start. The history
// needs no clearing pass: copies that reach a word not yet written in this
// stream yield zero and raise reference_error.
module lz_word_backref_decompressor #(
    parameter int HISTORY_WORDS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lzwbd_pkg::CFG_W-1:0] i_cfg_data,
    lzwbd_in_if.sink                    i_stream,
    lzwbd_out_if.source                 o_result
);

    lzwbd_pkg::t_cmd    cmd;
    lzwbd_pkg::t_status st;

    lzwbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_stream.valid),
        .o_in_ready (i_stream.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    lzwbd_dp #(
        .HISTORY_WORDS (HISTORY_WORDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_stream_byte     (i_stream.stream_byte),
        .i_stream_start    (i_stream.stream_start),
        .i_cmd             (cmd),
        .o_st              (st),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_word_a          (o_result.word_a),
        .o_word_b          (o_result.word_b),
        .o_word_c          (o_result.word_c),
        .o_word_d          (o_result.word_d),
        .o_word_count      (o_result.word_count),
        .o_run_last        (o_result.run_last),
        .o_output_done     (o_result.output_done),
        .o_reference_error (o_result.reference_error)
    );

endmodule

// ----- verif/lz_word_backref_decompressor_test.sv -----
`timescale 1ns / 1ps

module lz_word_backref_decompressor_test;

    localparam int CLK_PERIOD     = 10;
    localparam int HISTORY_WORDS  = 4096;
    localparam int SETTLE_CYCLES  = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIRECTED_N     = 25;
    localparam int PHASES         = 9;

    typedef struct packed {
        logic [lzwbd_pkg::WORD_W-1:0] word_a;
        logic [lzwbd_pkg::WORD_W-1:0] word_b;
        logic [lzwbd_pkg::WORD_W-1:0] word_c;
        logic [lzwbd_pkg::WORD_W-1:0] word_d;
        logic [lzwbd_pkg::CNT_W-1:0]  word_count;
        logic                         run_last;
        logic                         output_done;
        logic                         reference_error;
    } t_words;

    typedef struct packed {
        logic [lzwbd_pkg::BYTE_W-1:0] data;
        logic                         start;
        logic                         typed;
        t_words                       want;
    } t_stim_row;

    localparam t_words NO_WORDS = '0;
    localparam t_words LIT_FFFF = '{16'hffff, 16'h0, 16'h0, 16'h0, 3'd1, 1'b1, 1'b0, 1'b0};
    localparam t_words LIT_0000 = '{16'h0000, 16'h0, 16'h0, 16'h0, 3'd1, 1'b1, 1'b0, 1'b0};
    localparam t_words ESC_A755 = '{16'ha755, 16'h0, 16'h0, 16'h0, 3'd1, 1'b1, 1'b0, 1'b0};
    localparam t_words BAD_3    = '{16'h0, 16'h0, 16'h0, 16'h0, 3'd3, 1'b1, 1'b0, 1'b1};
    localparam t_words BAD_2    = '{16'h0, 16'h0, 16'h0, 16'h0, 3'd2, 1'b1, 1'b0, 1'b1};

    localparam t_stim_row DIRECTED [DIRECTED_N] = '{
        '{8'hff,               1'b1, 1'b0, NO_WORDS},  // all-ones literal opens a fresh stream
        '{8'hff,               1'b0, 1'b1, LIT_FFFF},
        '{8'h00,               1'b0, 1'b0, NO_WORDS},  // all-zeros literal
        '{8'h00,               1'b0, 1'b1, LIT_0000},
        '{8'h00,               1'b0, 1'b0, NO_WORDS},  // escaped near tag
        '{lzwbd_pkg::NEAR_TAG, 1'b0, 1'b0, NO_WORDS},
        '{8'h55,               1'b0, 1'b1, ESC_A755},
        '{8'h06,               1'b0, 1'b0, NO_WORDS},  // near copy overlapping its own output
        '{lzwbd_pkg::NEAR_TAG, 1'b0, 1'b0, NO_WORDS},
        '{8'h02,               1'b0, 1'b0, NO_WORDS},
        '{8'h03,               1'b0, 1'b0, NO_WORDS},  // near copy reaching before position zero
        '{lzwbd_pkg::NEAR_TAG, 1'b0, 1'b0, NO_WORDS},
        '{8'hff,               1'b0, 1'b1, BAD_3},
        '{8'h05,               1'b0, 1'b0, NO_WORDS},  // far copy of the opening words
        '{lzwbd_pkg::FAR_TAG,  1'b0, 1'b0, NO_WORDS},
        '{8'h00,               1'b0, 1'b0, NO_WORDS},
        '{8'h00,               1'b0, 1'b0, NO_WORDS},
        '{8'h02,               1'b0, 1'b0, NO_WORDS},  // far copy from the top of the range
        '{lzwbd_pkg::FAR_TAG,  1'b0, 1'b0, NO_WORDS},
        '{8'hff,               1'b0, 1'b0, NO_WORDS},
        '{8'hff,               1'b0, 1'b1, BAD_2},
        '{8'hff,               1'b0, 1'b0, NO_WORDS},  // longest far copy, overtaking its source
        '{lzwbd_pkg::FAR_TAG,  1'b0, 1'b0, NO_WORDS},
        '{8'h10,               1'b0, 1'b0, NO_WORDS},
        '{8'h00,               1'b0, 1'b0, NO_WORDS}
    };

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [lzwbd_pkg::CFG_W-1:0] cfg_data;

    lzwbd_in_if  stream_if ();
    lzwbd_out_if result_if ();

    lz_word_backref_decompressor #(
        .HISTORY_WORDS(HISTORY_WORDS)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_stream  (stream_if),
        .o_result  (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Decompressor state as the block should hold it
    logic [lzwbd_pkg::CFG_W-1:0]  size_reg;
    lzwbd_pkg::t_phase            parse_ph;
    logic [lzwbd_pkg::BYTE_W-1:0] low_byte;
    lzwbd_pkg::t_kind             tag_kind;
    logic [lzwbd_pkg::BYTE_W-1:0] far_low;
    int                           wr_pos;
    bit                           stream_full;
    logic [lzwbd_pkg::WORD_W-1:0] history [HISTORY_WORDS];
    logic [lzwbd_pkg::WORD_W-1:0] pack_words [lzwbd_pkg::RESULT_WORDS];
    int                           pack_n;
    bit                           pack_err;

    t_words            step_words [$];
    t_words            awaited_results [$];

    int                failures;
    int                quiet_cycles;
    int                sent_items;
    int                burst_left;

    function automatic int size_limit();
        if (size_reg == '0) return 1;
        if (size_reg > HISTORY_WORDS) return HISTORY_WORDS;
        return int'(size_reg);
    endfunction

    function automatic void close_pack();
        t_words r;
        if (pack_n == 0) return;
        r = '0;
        r.word_a          = pack_words[0];
        r.word_b          = (pack_n > 1) ? pack_words[1] : '0;
        r.word_c          = (pack_n > 2) ? pack_words[2] : '0;
        r.word_d          = (pack_n > 3) ? pack_words[3] : '0;
        r.word_count      = lzwbd_pkg::CNT_W'(pack_n);
        r.output_done     = stream_full;
        r.reference_error = pack_err;
        step_words.insert(step_words.size(), r);
        pack_n   = 0;
        pack_err = 1'b0;
    endfunction

    function automatic void emit_word(logic [lzwbd_pkg::WORD_W-1:0] value, bit bad);
        if (stream_full || wr_pos >= size_limit()) return;
        history[wr_pos]    = value;
        pack_words[pack_n] = value;
        pack_n++;
        if (bad) pack_err = 1'b1;
        wr_pos++;
        if (wr_pos >= size_limit()) stream_full = 1'b1;
        if (pack_n == lzwbd_pkg::RESULT_WORDS || stream_full) close_pack();
    endfunction

    // Move one word at a time so a word just written can be copied again.
    function automatic void copy_words(int src_start, int count, int lead_zeros);
        int src;
        for (int i = 0; i < count && !stream_full; i++) begin
            src = src_start + i - lead_zeros;
            if (i < lead_zeros || src >= wr_pos) emit_word('0, 1'b1);
            else emit_word(history[src], 1'b0);
        end
    endfunction

    // A byte that arrives once the output is full leaves step_words empty.
    function automatic void decompress_byte(logic [lzwbd_pkg::BYTE_W-1:0] b, logic start);
        logic [lzwbd_pkg::BYTE_W-1:0] tag;
        step_words.delete();
        pack_n   = 0;
        pack_err = 1'b0;
        if (start) begin
            parse_ph    = lzwbd_pkg::PH_LOW;
            low_byte    = '0;
            tag_kind    = lzwbd_pkg::KIND_NONE;
            far_low     = '0;
            wr_pos      = 0;
            stream_full = 1'b0;
        end
        if (wr_pos >= size_limit()) stream_full = 1'b1;
        if (stream_full) return;
        case (parse_ph)
            lzwbd_pkg::PH_LOW: begin
                low_byte = b;
                parse_ph = lzwbd_pkg::PH_HIGH;
            end
            lzwbd_pkg::PH_HIGH: begin
                if (b == lzwbd_pkg::NEAR_TAG || b == lzwbd_pkg::FAR_TAG) begin
                    tag_kind = (b == lzwbd_pkg::NEAR_TAG) ? lzwbd_pkg::KIND_NEAR
                                                          : lzwbd_pkg::KIND_FAR;
                    if (low_byte == '0) parse_ph = lzwbd_pkg::PH_ESCAPE;
                    else if (b == lzwbd_pkg::NEAR_TAG) parse_ph = lzwbd_pkg::PH_NEAR_OFS;
                    else parse_ph = lzwbd_pkg::PH_FAR_LOW;
                end else begin
                    parse_ph = lzwbd_pkg::PH_LOW;
                    emit_word({b, low_byte}, 1'b0);
                end
            end
            lzwbd_pkg::PH_ESCAPE: begin
                parse_ph = lzwbd_pkg::PH_LOW;
                tag = (tag_kind == lzwbd_pkg::KIND_NEAR) ? lzwbd_pkg::NEAR_TAG
                                                         : lzwbd_pkg::FAR_TAG;
                emit_word({tag, b}, 1'b0);
            end
            lzwbd_pkg::PH_NEAR_OFS: begin
                parse_ph = lzwbd_pkg::PH_LOW;
                if (int'(b) <= wr_pos) copy_words(wr_pos - int'(b), int'(low_byte), 0);
                else copy_words(0, int'(low_byte), int'(b) - wr_pos);
            end
            lzwbd_pkg::PH_FAR_LOW: begin
                far_low  = b;
                parse_ph = lzwbd_pkg::PH_FAR_HIGH;
            end
            lzwbd_pkg::PH_FAR_HIGH: begin
                parse_ph = lzwbd_pkg::PH_LOW;
                copy_words(int'({b, far_low}), int'(low_byte), 0);
            end
            default: parse_ph = lzwbd_pkg::PH_LOW;
        endcase
        close_pack();
        if (step_words.size() > 0) step_words[$].run_last = 1'b1;
    endfunction

    function automatic logic [lzwbd_pkg::BYTE_W-1:0] rand_byte();
        return lzwbd_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // Now and then restart the stream in the middle of a token.
    function automatic logic stray_start();
        return $urandom_range(0, 39) == 0;
    endfunction

    function automatic void check_field(string name, logic [lzwbd_pkg::WORD_W-1:0] want,
                                        logic [lzwbd_pkg::WORD_W-1:0] got);
        if (want === got) return;
        failures++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    endfunction

    task automatic send_byte(input logic [lzwbd_pkg::BYTE_W-1:0] d, input logic s,
                             input logic typed = 1'b0, input t_words want = NO_WORDS);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                stream_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        stream_if.valid        = 1'b1;
        stream_if.stream_byte  = d;
        stream_if.stream_start = s;
        do @(posedge clk); while (!stream_if.ready);
        decompress_byte(d, s);
        sent_items++;
        if (typed) awaited_results.insert(awaited_results.size(), want);
        else foreach (step_words[i]) awaited_results.insert(awaited_results.size(),
                                                            step_words[i]);
    endtask

    task automatic send_token(input bit long_runs, input bit open_stream);
        int   pick;
        int   count;
        int   base;
        int   pos;
        logic s;
        logic [lzwbd_pkg::BYTE_W-1:0] hi;
        if (open_stream) s = 1'b1;
        else if (stream_full) s = $urandom_range(0, 1) == 1;
        else s = $urandom_range(0, 19) == 0;
        base = s ? 0 : wr_pos;
        if (long_runs) begin
            pick  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 54) : $urandom_range(55, 99);
            count = $urandom_range(200, 255);
        end else begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       count = $urandom_range(41, 255);
                1, 2:    count = $urandom_range(9, 40);
                default: count = $urandom_range(1, 8);
            endcase
        end
        if (pick < 8) begin
            send_byte(rand_byte(), s);
        end else if (pick < 45) begin
            send_byte(rand_byte(), s);
            do hi = rand_byte(); while (hi == lzwbd_pkg::NEAR_TAG || hi == lzwbd_pkg::FAR_TAG);
            send_byte(hi, stray_start());
        end else if (pick < 55) begin
            send_byte(8'h00, s);
            send_byte(($urandom_range(0, 1) == 1) ? lzwbd_pkg::NEAR_TAG : lzwbd_pkg::FAR_TAG,
                      stray_start());
            send_byte(rand_byte(), stray_start());
        end else if (pick < 80) begin
            send_byte(lzwbd_pkg::BYTE_W'(count), s);
            send_byte(lzwbd_pkg::NEAR_TAG, stray_start());
            if (base > 0 && $urandom_range(0, 6) != 0)
                send_byte(lzwbd_pkg::BYTE_W'($urandom_range(1, (base < 255) ? base : 255)),
                          stray_start());
            else
                send_byte(rand_byte(), stray_start());
        end else begin
            send_byte(lzwbd_pkg::BYTE_W'(count), s);
            send_byte(lzwbd_pkg::FAR_TAG, stray_start());
            if (base > 0 && $urandom_range(0, 6) != 0) pos = $urandom_range(0, base - 1);
            else pos = $urandom_range(0, 65535);
            send_byte(pos[7:0], stray_start());
            send_byte(pos[15:8], stray_start());
        end
    endtask

    // Drop valid and hold off until every expected transaction has arrived.
    task automatic wait_idle();
        @(negedge clk);
        stream_if.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver stalls on a pattern that changes every so often.
    initial begin
        int pattern_left;
        int pattern_kind;
        int period;
        int tick;
        pattern_left    = 0;
        pattern_kind    = 0;
        period          = 2;
        tick            = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (pattern_left == 0) begin
                pattern_kind = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 200);
                period       = $urandom_range(2, 9);
            end
            pattern_left--;
            tick++;
            case (pattern_kind)
                0:       result_if.ready = 1'b1;
                1:       result_if.ready = $urandom_range(0, 3) != 0;
                2:       result_if.ready = (tick % period) != 0;
                default: result_if.ready = $urandom_range(0, 7) == 0;
            endcase
        end
    end

    always @(posedge clk) begin
        t_words got;
        t_words want;
        if (rst_n) begin
            got = {result_if.word_a, result_if.word_b, result_if.word_c, result_if.word_d,
                   result_if.word_count, result_if.run_last, result_if.output_done,
                   result_if.reference_error};
            if (result_if.valid && result_if.ready) begin
                if (awaited_results.size() == 0) begin
                    failures++;
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, got);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("word_a", want.word_a, got.word_a);
                    check_field("word_b", want.word_b, got.word_b);
                    check_field("word_c", want.word_c, got.word_c);
                    check_field("word_d", want.word_d, got.word_d);
                    check_field("word_count", 16'(want.word_count), 16'(got.word_count));
                    check_field("run_last", 16'(want.run_last), 16'(got.run_last));
                    check_field("output_done", 16'(want.output_done), 16'(got.output_done));
                    check_field("reference_error", 16'(want.reference_error),
                                16'(got.reference_error));
                end
            end
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                          quota;
        logic [lzwbd_pkg::CFG_W-1:0] size_plan;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = '0;
        stream_if.valid        = 1'b0;
        stream_if.stream_byte  = '0;
        stream_if.stream_start = 1'b0;
        failures               = 0;
        quiet_cycles           = 0;
        sent_items             = 0;
        burst_left             = 0;
        size_reg               = lzwbd_pkg::CFG_RESET;
        parse_ph               = lzwbd_pkg::PH_LOW;
        low_byte               = '0;
        tag_kind               = lzwbd_pkg::KIND_NONE;
        far_low                = '0;
        wr_pos                 = 0;
        stream_full            = 1'b0;
        pack_n                 = 0;
        pack_err               = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       size_plan = lzwbd_pkg::CFG_RESET;
                1:       size_plan = '0;
                2:       size_plan = '1;
                3:       size_plan = lzwbd_pkg::CFG_W'($urandom_range(2, 40));
                4:       size_plan = lzwbd_pkg::CFG_W'(1);
                5:       size_plan = lzwbd_pkg::CFG_W'($urandom_range(41, 300));
                6:       size_plan = lzwbd_pkg::CFG_W'(HISTORY_WORDS + 1);
                // Shrink to at most what the running stream has already written.
                7:       size_plan = lzwbd_pkg::CFG_W'($urandom_range(1, (wr_pos > 1) ? wr_pos : 1));
                default: size_plan = lzwbd_pkg::CFG_W'($urandom_range(2, HISTORY_WORDS));
            endcase
            @(negedge clk);
            cfg_we   = 1'b1;
            cfg_data = size_plan;
            @(negedge clk);
            cfg_we   = 1'b0;
            size_reg = size_plan;

            // Long copies in the full-size phase aim to fill the whole output.
            sent_items = 0;
            quota      = (p == 2) ? 70 : 20;
            send_token(p == 2, p == 2 || (p != 7 && $urandom_range(0, 3) != 0));
            while (sent_items < quota) send_token(p == 2, 1'b0);
        end

        wait_idle();
        if (failures == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
